[rtl/core/iir_df1_pkg.sv]
// Shared types and constants for the direct-form-I IIR filter.
`default_nettype none

package iir_df1_pkg;

  localparam int SampleW     = 16;
  localparam int CoefW       = 16;
  localparam int NumRegs     = 7;
  localparam int NumFf       = 4;
  localparam int HistDepth   = 3;
  localparam int CfgIdxW     = 3;
  localparam int TapW        = 3;
  localparam int ProdW       = 32;
  localparam int AccW        = 35;
  localparam int FracShift   = 13;
  localparam int RoundBias   = 4096;
  localparam int RegFf0      = 0;

  localparam logic signed [CoefW-1:0] CoefResetB0 = 16'sd8192;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_RND,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic            load;
    logic [TapW-1:0] tap;
    logic            mult_en;
    logic            acc_en;
    logic            commit;
    logic            load_out;
  } dp_cmd_t;

endpackage

`default_nettype wire

[rtl/core/iir_df1_ctrl.sv]
// Sequencer for the shared multiply-accumulate and the output handshake.
`default_nettype none

module iir_df1_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output iir_df1_pkg::dp_cmd_t     cmd
);
  import iir_df1_pkg::*;

  state_t          state_r, state_nxt;
  logic [TapW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;
  logic            accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) || ((state_r == ST_RND) && out_free));
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.tap       = cnt_r;
    cmd.load      = accept;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_MAC;
          cnt_nxt   = '0;
        end
      end
      ST_MAC: begin
        cmd.mult_en = (cnt_r < TapW'(NumRegs));
        cmd.acc_en  = (cnt_r != '0);
        cnt_nxt     = cnt_r + 1'b1;
        if (cnt_r == TapW'(NumRegs)) begin
          state_nxt = ST_RND;
        end
      end
      ST_RND: begin
        cmd.commit = 1'b1;
        if (out_free) begin
          cmd.load_out = 1'b1;
          if (accept) begin
            state_nxt = ST_MAC;
            cnt_nxt   = '0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

endmodule

`default_nettype wire

[rtl/core/iir_df1_dp.sv]
// Coefficients, histories, shared multiplier, accumulator, round and saturate.
`default_nettype none

module iir_df1_dp #(
  parameter int FEEDFORWARD_TAPS = 4,
  parameter int FEEDBACK_TAPS    = 4,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire logic                                      cfg_wr_en,
  input  wire logic        [iir_df1_pkg::CfgIdxW-1:0]    cfg_index,
  input  wire logic        [iir_df1_pkg::CoefW-1:0]      cfg_wdata,
  input  wire logic signed [iir_df1_pkg::SampleW-1:0]    in_sample_in,
  input  wire logic                                      in_start_of_signal,
  input  wire iir_df1_pkg::dp_cmd_t                      cmd,
  output logic signed      [iir_df1_pkg::SampleW-1:0]    out_sample_out,
  output logic                                           out_saturated
);
  import iir_df1_pkg::*;

  localparam int SatBits = (SAMPLE_BITS < SampleW) ? SAMPLE_BITS : SampleW;
  localparam logic signed [AccW-1:0] SatHi =
    (AccW'(1) << (SatBits - 1)) - AccW'(1);
  localparam logic signed [AccW-1:0] SatLo = ~SatHi;

  logic signed [CoefW-1:0]   coef_r [NumRegs];
  logic signed [SampleW-1:0] x_r;
  logic signed [SampleW-1:0] xh_r [HistDepth];
  logic signed [SampleW-1:0] yh_r [HistDepth];
  logic signed [ProdW-1:0]   prod_r;
  logic                      neg_r;
  logic signed [AccW-1:0]    acc_r;

  logic [NumRegs-1:0]        tap_en;
  logic signed [SampleW-1:0] opd_vec [NumRegs];
  logic signed [SampleW-1:0] opd;
  logic signed [CoefW-1:0]   coef;
  logic signed [AccW-1:0]    biased;
  logic signed [AccW-1:0]    y_full;
  logic signed [AccW-1:0]    y_sel;
  logic                      sat;
  logic signed [SampleW-1:0] y_sat;

  // b_k taps first, then a_1..a_3
  always_comb begin
    for (int k = 0; k < NumRegs; k++) begin
      if (k < NumFf) begin
        tap_en[k] = (k < FEEDFORWARD_TAPS);
      end else begin
        tap_en[k] = ((k - NumFf + 1) < FEEDBACK_TAPS);
      end
    end
    opd_vec[0] = x_r;
    for (int k = 0; k < HistDepth; k++) begin
      opd_vec[1 + k]     = xh_r[k];
      opd_vec[NumFf + k] = yh_r[k];
    end
  end

  always_comb begin
    opd  = '0;
    coef = '0;
    if (cmd.tap < TapW'(NumRegs)) begin
      opd = opd_vec[cmd.tap];
      if (tap_en[cmd.tap]) begin
        coef = coef_r[cmd.tap];
      end
    end
  end

  always_comb begin
    biased = acc_r + AccW'(RoundBias);
    y_full = biased >>> FracShift;
    sat    = 1'b0;
    y_sel  = y_full;
    if (y_full > SatHi) begin
      y_sel = SatHi;
      sat   = 1'b1;
    end else if (y_full < SatLo) begin
      y_sel = SatLo;
      sat   = 1'b1;
    end
    y_sat = y_sel[SampleW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NumRegs; i++) begin
        coef_r[i] <= (i == RegFf0) ? CoefResetB0 : '0;
      end
    end else if (cfg_wr_en && (cfg_index < CfgIdxW'(NumRegs))) begin
      coef_r[cfg_index] <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < HistDepth; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (cmd.load && in_start_of_signal) begin
      for (int i = 0; i < HistDepth; i++) begin
        xh_r[i] <= '0;
        yh_r[i] <= '0;
      end
    end else if (cmd.commit) begin
      for (int i = HistDepth - 1; i > 0; i--) begin
        xh_r[i] <= xh_r[i-1];
        yh_r[i] <= yh_r[i-1];
      end
      xh_r[0] <= x_r;
      yh_r[0] <= y_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r <= in_sample_in;
    end
    if (cmd.mult_en) begin
      prod_r <= coef * opd;
      neg_r  <= (cmd.tap >= TapW'(NumFf));
    end
    if (cmd.load) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= neg_r ? (acc_r - AccW'(prod_r)) : (acc_r + AccW'(prod_r));
    end
    if (cmd.load_out) begin
      out_sample_out <= y_sat;
      out_saturated  <= sat;
    end
  end

endmodule

`default_nettype wire

[rtl/core/iir_filter_direct_form_one.sv]
// Direct-form-I IIR filter top level: four feedforward, three feedback taps.
// A new beat is taken only once the previous one has reached the round/saturate
// step; one shared 16x16 multiplier walks the seven taps, then the last
// product is accumulated and the sum is rounded and saturated.
// A finished result waits in the output register while the next beat is taken.
// Reset: b0 = 1.0, other coefficients zero, histories zero, output empty.
`default_nettype none

module iir_filter_direct_form_one #(
  parameter int FEEDFORWARD_TAPS = 4,
  parameter int FEEDBACK_TAPS    = 4,
  parameter int SAMPLE_BITS      = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   cfg_wr_en,
  input  wire logic        [iir_df1_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic        [iir_df1_pkg::CoefW-1:0]   cfg_wdata,
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic signed [iir_df1_pkg::SampleW-1:0] in_sample_in,
  input  wire logic                                   in_start_of_signal,
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic signed      [iir_df1_pkg::SampleW-1:0] out_sample_out,
  output logic                                        out_saturated
);
  import iir_df1_pkg::*;

  dp_cmd_t cmd;

  iir_df1_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  iir_df1_dp #(
    .FEEDFORWARD_TAPS (FEEDFORWARD_TAPS),
    .FEEDBACK_TAPS    (FEEDBACK_TAPS),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_sample_in       (in_sample_in),
    .in_start_of_signal (in_start_of_signal),
    .cmd                (cmd),
    .out_sample_out     (out_sample_out),
    .out_saturated      (out_saturated)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while previous beat still in the MAC loop");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("pending result overwritten");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !cmd.commit)
    else $error("history shifted twice for one beat");

  a_tap_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mult_en |-> (cmd.tap < TapW'(NumRegs)))
    else $error("multiply on tap out of range");

endmodule

`default_nettype wire
